// ===== hw/rtl/hfd_pkg.sv =====
// Shared types, constants and the CRC-8 function of the humidity/temperature frame decoder.
package hfd_pkg;

   localparam int RawWidth   = 16;
   localparam int ValueWidth = 15;
   localparam int CompWidth  = 13;

   localparam logic [7:0] CrcPoly = 8'h31;

   // Conversion coefficients, 16-bit raw word scaled by 2^-16
   localparam logic [14:0] TempCoef  = 15'd17572;
   localparam logic [14:0] HumCoef   = 15'd12500;
   localparam logic signed [15:0] TempOffset = 16'sd4685;
   localparam logic signed [15:0] HumOffset  = 16'sd600;

   // Compensation: 15*(2500 - T) / 100, the division done by reciprocal 2^25/100 rounded up
   localparam logic signed [15:0] TempRef    = 16'sd2500;
   localparam int                 RecipShift = 25;
   localparam logic [18:0]        RecipHund  = 19'd335545;

   localparam logic KindTemp = 1'b0;
   localparam logic KindHum  = 1'b1;

   typedef struct packed {
      logic                         store;
      logic                         clear;
      logic signed [ValueWidth-1:0] temperature;
   } temp_upd_type;

   typedef struct packed {
      logic                        valid;
      logic signed [CompWidth-1:0] comp_term;
   } temp_info_type;

   function automatic logic [7:0] crc8_word(input logic [RawWidth-1:0] data);
      logic [7:0] crc;
      logic       fb;
      crc = 8'h00;
      for (int i = RawWidth - 1; i >= 0; i--) begin
         fb  = crc[7] ^ data[i];
         crc = {crc[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
      end
      return crc;
   endfunction

endpackage

// ===== hw/rtl/humidity_temp_frame_decoder.sv =====
// Top level of the humidity/temperature sensor frame decoder.
// Each transfer on the req_ side carries one sensor frame (two raw bytes and their CRC-8,
// polynomial 0x31, zero init) tagged temperature or humidity; each one yields exactly one
// transfer on the rsp_ side. Temperature comes out in 0.01 degC and, when its CRC holds,
// is kept for later humidity frames; a temperature frame with a bad CRC drops the stored
// value's valid flag. Humidity comes out in 0.01 %RH and is corrected by the stored
// temperature when one is valid. A bad CRC gives value 0 with crc_ok low. A frame passes
// the input register, then the result register, and the block takes one frame every cycle
// while rsp_tready does not hold the result register; the single conversion pass between
// the two registers also sees the temperature stored by the frame just ahead of it.
module humidity_temp_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] raw_high, [15:8] raw_low, [23:16] crc_byte
   input  logic        req_tuser,   // [0] is_humidity
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [14:0] value (signed), [15] zero
   output logic [2:0]  rsp_tuser    // [0] crc_ok, [1] kind_out, [2] compensated
);
   import hfd_pkg::*;

   // Input register
   logic        in_vld_ff, in_vld_in;
   logic [23:0] in_data_ff, in_data_in;
   logic        in_kind_ff, in_kind_in;

   // Result register
   logic                         out_vld_ff, out_vld_in;
   logic signed [ValueWidth-1:0] out_value_ff, out_value_in;
   logic                         out_ok_ff, out_ok_in;
   logic                         out_kind_ff, out_kind_in;
   logic                         out_comp_ff, out_comp_in;

   logic advance;
   logic move;

   logic                         conv_ok;
   logic signed [ValueWidth-1:0] conv_value;
   logic                         conv_comp;
   temp_upd_type                 conv_upd;
   temp_upd_type                 store_upd;
   temp_info_type                temp_info;

   // Result register frees up when empty or when its transfer completes this cycle
   assign advance    = !out_vld_ff || rsp_tready;
   assign move       = in_vld_ff && advance;
   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_data_in = in_data_ff;
      in_kind_in = in_kind_ff;
      if (req_tvalid && req_tready) begin
         // Take the next frame while the current one moves on
         in_vld_in  = 1'b1;
         in_data_in = req_tdata;
         in_kind_in = req_tuser;
      end else if (move) begin
         in_vld_in = 1'b0;
      end
   end

   hfd_conv u_conv (
      .kind        (in_kind_ff),
      .raw_high    (in_data_ff[7:0]),
      .raw_low     (in_data_ff[15:8]),
      .crc_byte    (in_data_ff[23:16]),
      .info        (temp_info),
      .crc_ok      (conv_ok),
      .value       (conv_value),
      .compensated (conv_comp),
      .upd         (conv_upd)
   );

   // Touch the stored temperature only when the frame really moves to the result register
   always_comb begin
      store_upd       = conv_upd;
      store_upd.store = conv_upd.store && move;
      store_upd.clear = conv_upd.clear && move;
   end

   hfd_temp_store u_temp_store (
      .clock (clock),
      .reset (reset),
      .upd   (store_upd),
      .info  (temp_info)
   );

   always_comb begin
      out_vld_in   = out_vld_ff;
      out_value_in = out_value_ff;
      out_ok_in    = out_ok_ff;
      out_kind_in  = out_kind_ff;
      out_comp_in  = out_comp_ff;
      if (move) begin
         out_vld_in   = 1'b1;
         out_value_in = conv_value;
         out_ok_in    = conv_ok;
         out_kind_in  = in_kind_ff;
         out_comp_in  = conv_comp;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      in_data_ff   <= in_data_in;
      in_kind_ff   <= in_kind_in;
      out_value_ff <= out_value_in;
      out_ok_ff    <= out_ok_in;
      out_kind_ff  <= out_kind_in;
      out_comp_ff  <= out_comp_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {1'b0, out_value_ff};
   assign rsp_tuser  = {out_comp_ff, out_kind_ff, out_ok_ff};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1] == KindTemp) |-> !rsp_tuser[2])
      else $error("temperature result marked compensated");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata == '0) && !rsp_tuser[2])
      else $error("failed CRC result carries data");
   assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && out_vld_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted while both registers are held");

endmodule

// ===== hw/rtl/hfd_temp_store.sv =====
// Stored temperature, its valid flag and the humidity compensation term derived from it.
module hfd_temp_store (
   input  logic                  clock,
   input  logic                  reset,
   input  hfd_pkg::temp_upd_type upd,
   output hfd_pkg::temp_info_type info
);
   import hfd_pkg::*;

   logic signed [ValueWidth-1:0] last_temp_ff, last_temp_in;
   logic                         valid_ff, valid_in;

   logic signed [15:0] diff;
   logic signed [19:0] scaled;
   logic        [17:0] mag;
   logic        [36:0] prod;
   logic        [11:0] quot;

   always_comb begin
      last_temp_in = last_temp_ff;
      valid_in     = valid_ff;
      if (upd.store) begin
         last_temp_in = upd.temperature;
         valid_in     = 1'b1;
      end else if (upd.clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_temp_ff <= '0;
         valid_ff     <= 1'b0;
      end else begin
         last_temp_ff <= last_temp_in;
         valid_ff     <= valid_in;
      end
   end

   // 15*(2500 - T), then divide magnitude by 100 and restore the sign (truncate toward zero)
   always_comb begin
      diff   = TempRef - 16'(last_temp_ff);
      scaled = (20'(diff) <<< 4) - 20'(diff);
      mag    = scaled[19] ? 18'(-scaled) : 18'(scaled);
      prod   = 37'(mag) * 37'(RecipHund);
      quot   = prod[RecipShift +: 12];
      info.valid     = valid_ff;
      info.comp_term = scaled[19] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
   end

   assert property (@(posedge clock) disable iff (reset)
      upd.store |=> valid_ff && (last_temp_ff == $past(upd.temperature)))
      else $error("stored temperature not taken");
   assert property (@(posedge clock) disable iff (reset)
      upd.clear && !upd.store |=> !valid_ff)
      else $error("temperature valid flag not cleared");
   assert property (@(posedge clock) disable iff (reset)
      !upd.store && !upd.clear |=> $stable(last_temp_ff) && $stable(valid_ff))
      else $error("temperature store changed without update");

endmodule

// ===== hw/rtl/hfd_conv.sv =====
// Frame datapath: CRC check, raw-to-unit conversion and humidity compensation.
module hfd_conv (
   input  logic                                  kind,
   input  logic [7:0]                            raw_high,
   input  logic [7:0]                            raw_low,
   input  logic [7:0]                            crc_byte,
   input  hfd_pkg::temp_info_type                info,
   output logic                                  crc_ok,
   output logic signed [hfd_pkg::ValueWidth-1:0] value,
   output logic                                  compensated,
   output hfd_pkg::temp_upd_type                 upd
);
   import hfd_pkg::*;

   logic [RawWidth-1:0] raw;
   logic [14:0]         coef;
   logic [30:0]         prod;
   logic [14:0]         scaled;
   logic signed [15:0]  temp_val;
   logic signed [15:0]  hum_raw;
   logic signed [15:0]  hum_abs;
   logic signed [15:0]  hum_val;

   always_comb begin
      raw    = {raw_high, raw_low};
      crc_ok = (crc8_word(raw) == crc_byte);

      // One multiplier, coefficient picked by frame kind
      coef   = (kind == KindHum) ? HumCoef : TempCoef;
      prod   = 31'(raw) * 31'(coef);
      scaled = prod[30:16];

      temp_val = $signed({1'b0, scaled}) - TempOffset;
      hum_raw  = $signed({1'b0, scaled}) - HumOffset;
      hum_abs  = hum_raw[15] ? -hum_raw : hum_raw;
      hum_val  = info.valid ? hum_abs - 16'(info.comp_term) : hum_abs;

      value       = '0;
      compensated = 1'b0;
      upd.store       = 1'b0;
      upd.clear       = 1'b0;
      upd.temperature = temp_val[ValueWidth-1:0];

      if (kind == KindTemp) begin
         upd.store = crc_ok;
         upd.clear = !crc_ok;
         if (crc_ok) begin
            value = temp_val[ValueWidth-1:0];
         end
      end else if (crc_ok) begin
         value       = hum_val[ValueWidth-1:0];
         compensated = info.valid;
      end
   end

endmodule

// ===== sim/humidity_temp_frame_decoder_tb.sv =====
// Self-checking testbench for the humidity/temperature sensor frame decoder.
`timescale 1ns / 100ps

module humidity_temp_frame_decoder_tb;
   import hfd_pkg::*;

   // One decoded reading as it should leave the rsp_ side
   typedef struct packed {
      logic                  crc_ok;
      logic                  kind;
      logic [ValueWidth-1:0] value;
      logic                  compensated;
   } reading_type;

   localparam int ReportLimit   = 10;
   localparam int StallLimit    = 2000;  // cycles without any transfer
   localparam int DrainCycles   = 8;     // input and result registers plus margin
   localparam int RandomFrames  = 450;
   localparam int IdlePercent   = 25;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [7:0] raw_high, [15:8] raw_low, [23:16] crc_byte
   logic        req_tuser = 1'b0; // [0] is_humidity
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [14:0] value (signed), [15] zero
   logic [2:0]  rsp_tuser;        // [0] crc_ok, [1] kind_out, [2] compensated

   // Predictor copy of the block's stored temperature
   int          stored_temp = 0;
   logic        stored_temp_ok = 1'b0;

   reading_type pending_readings[$];
   int          error_count = 0;
   int          stall_cycles = 0;
   logic        steady_flow = 1'b0;  // when high neither side idles

   humidity_temp_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // CRC-8, polynomial 0x31, zero init, high byte first, MSB first
   function automatic logic [7:0] frame_crc(input logic [7:0] hi, input logic [7:0] lo);
      logic [7:0] crc;
      logic [7:0] bytes [2];
      bytes[0] = hi;
      bytes[1] = lo;
      crc = 8'h00;
      for (int b = 0; b < 2; b++) begin
         crc = crc ^ bytes[b];
         for (int k = 0; k < 8; k++) begin
            if (crc[7]) crc = {crc[6:0], 1'b0} ^ CrcPoly;
            else        crc = {crc[6:0], 1'b0};
         end
      end
      return crc;
   endfunction

   // Decode one accepted frame and advance the stored temperature
   function automatic reading_type decode_frame(input logic kind, input logic [7:0] hi,
                                                input logic [7:0] lo, input logic [7:0] crc);
      reading_type r;
      int          raw;
      int          level;
      raw           = int'({hi, lo});
      r.crc_ok      = (frame_crc(hi, lo) == crc);
      r.kind        = kind;
      r.compensated = 1'b0;
      level         = 0;
      if (kind == KindTemp) begin
         if (r.crc_ok) begin
            level          = -4685 + ((17572 * raw) >> 16);
            stored_temp    = level;
            stored_temp_ok = 1'b1;
         end else begin
            // a broken temperature frame only drops the valid flag
            stored_temp_ok = 1'b0;
         end
      end else if (r.crc_ok) begin
         level = -600 + ((12500 * raw) >> 16);
         if (level < 0) level = -level;
         if (stored_temp_ok) begin
            // int division truncates toward zero
            level         = level - (15 * (2500 - stored_temp)) / 100;
            r.compensated = 1'b1;
         end
      end
      r.value = level[ValueWidth-1:0];
      return r;
   endfunction

   // Random receiver stall, held off during the steady stretch
   always @(posedge clock) begin
      rsp_tready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= IdlePercent);
   end

   // Sample both channels at the falling edge, where every input is settled;
   // a transfer seen here completes at the next rising edge.
   always @(negedge clock) begin
      reading_type want;
      reading_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pending_readings.push_back(decode_frame(req_tuser, req_tdata[7:0],
                                                    req_tdata[15:8], req_tdata[23:16]));
         if (rsp_tvalid && rsp_tready) begin
            got = '{crc_ok: rsp_tuser[0], kind: rsp_tuser[1], value: rsp_tdata[14:0],
                    compensated: rsp_tuser[2]};
            if (pending_readings.size() == 0) begin
               error_count++;
               if (error_count <= ReportLimit)
                  $display("unexpected reading: crc_ok=%0b kind=%0b value=%0d comp=%0b",
                           got.crc_ok, got.kind, $signed(got.value), got.compensated);
            end else begin
               want = pending_readings.pop_front();
               if (got !== want || rsp_tdata[15] !== 1'b0) begin
                  error_count++;
                  if (error_count <= ReportLimit)
                     $display("reading mismatch: exp crc_ok=%0b kind=%0b value=%0d comp=%0b",
                              want.crc_ok, want.kind, $signed(want.value), want.compensated,
                              " / got crc_ok=%0b kind=%0b value=%0d comp=%0b pad=%0b",
                              got.crc_ok, got.kind, $signed(got.value), got.compensated,
                              rsp_tdata[15]);
               end
            end
         end
         // watchdog: end the run when nothing moves for too long
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= StallLimit) begin
            $display("watchdog: no transfer for %0d cycles", StallLimit);
            $display("humidity_temp_frame_decoder_tb NOT OK");
            $finish;
         end
      end
   end

   // Present one frame and hold it until the transfer completes
   task automatic send_frame(input logic kind, input logic [7:0] hi, input logic [7:0] lo,
                             input logic [7:0] crc);
      logic took;
      while (!steady_flow && $urandom_range(0, 99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {crc, lo, hi};
      req_tuser  <= kind;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
   endtask

   task automatic send_good(input logic kind, input logic [15:0] raw);
      send_frame(kind, raw[15:8], raw[7:0], frame_crc(raw[15:8], raw[7:0]));
   endtask

   // Full-scale raw words, the negative humidity fold and compensation limits
   task automatic test_conversion_extremes();
      send_good(KindHum, 16'hFFFF);    // no temperature stored yet
      send_good(KindHum, 16'h0000);    // -6 %RH folds to +6
      send_good(KindTemp, 16'h0000);   // coldest reading
      send_good(KindHum, 16'd3146);    // zero humidity, largest downward correction
      send_good(KindHum, 16'h0000);
      send_good(KindTemp, 16'hFFFF);   // hottest reading
      send_good(KindHum, 16'hFFFF);    // largest corrected humidity
      send_good(KindHum, 16'd3146);
   endtask

   // Broken checksums on both frame kinds and their effect on the stored temperature
   task automatic test_crc_failures();
      send_frame(KindTemp, 8'hFF, 8'hFF, frame_crc(8'hFF, 8'hFF) ^ 8'h80);
      send_good(KindHum, 16'h8000);    // flag dropped: no correction
      send_good(KindTemp, 16'h6666);
      send_frame(KindHum, 8'h12, 8'h34, frame_crc(8'h12, 8'h34) ^ 8'h01);
      send_good(KindHum, 16'h1234);    // bad humidity left the temperature intact
      send_frame(KindHum, 8'hFF, 8'h00, 8'hFF);
      send_frame(KindTemp, 8'h00, 8'hFF, 8'h00);
      send_frame(KindTemp, 8'hA5, 8'h5A, 8'hFF);
      send_good(KindHum, 16'h4000);
   endtask

   // Temperatures on both sides of 25 degC, so the correction truncates both ways
   task automatic test_compensation();
      send_good(KindTemp, 16'h5F00);
      send_good(KindHum, 16'h7777);
      send_good(KindTemp, 16'h6A00);
      send_good(KindHum, 16'h7777);
      send_good(KindTemp, 16'h6600);
      send_good(KindHum, 16'h0C00);
      send_good(KindHum, 16'hC000);
   endtask

   // Mostly well-formed frames with random content, some corrupted checksums
   task automatic test_random_frames();
      logic [15:0] raw;
      logic [7:0]  crc;
      logic        kind;
      int          pick;
      for (int n = 0; n < RandomFrames; n++) begin
         steady_flow = (n >= 150 && n < 250);
         kind = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 19);
         if (pick == 0)      raw = 16'h0000;
         else if (pick == 1) raw = 16'hFFFF;
         else                raw = 16'($urandom_range(0, 16'hFFFF));
         crc  = frame_crc(raw[15:8], raw[7:0]);
         pick = $urandom_range(0, 9);
         if (pick == 0)      crc = crc ^ (8'h01 << $urandom_range(0, 7));
         else if (pick == 1) crc = 8'($urandom_range(0, 255));
         send_frame(kind, raw[15:8], raw[7:0], crc);
      end
      steady_flow = 1'b0;
   endtask

   // Drop valid and wait for every reading to come back
   task automatic drain_readings();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_conversion_extremes();
      test_crc_failures();
      test_compensation();
      test_random_frames();
      drain_readings();
      if (error_count == 0)
         $display("humidity_temp_frame_decoder_tb OK");
      else
         $display("humidity_temp_frame_decoder_tb NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/hfd_pkg.sv
hw/rtl/hfd_temp_store.sv
hw/rtl/hfd_conv.sv
hw/rtl/humidity_temp_frame_decoder.sv
sim/humidity_temp_frame_decoder_tb.sv
